FILE: rtl/core/bsle_pkg.sv
// Package for the list engine: action and status codes, cell control bundle.
// No dependencies.
`timescale 1ns / 1ps
package bsle_pkg;
   typedef enum logic [3:0] {
      ACT_APPEND = 4'd0, ACT_PUSH_FRONT = 4'd1, ACT_INSERT_AT = 4'd2,
      ACT_POP_TAIL = 4'd3, ACT_POP_HEAD = 4'd4, ACT_DEL_FIRST = 4'd5,
      ACT_DEL_ALL = 4'd6, ACT_FIND = 4'd7, ACT_BSEARCH = 4'd8,
      ACT_READ = 4'd9, ACT_WRITE = 4'd10, ACT_REPL_LAST = 4'd11,
      ACT_REPL_ALL = 4'd12, ACT_SORT_UP = 4'd13, ACT_SORT_DOWN = 4'd14,
      ACT_NONE = 4'd15
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BADIDX = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Per-cycle command broadcast to every cell.
   typedef enum logic [2:0] {
      CELL_HOLD = 3'd0, CELL_SHIFT_UP = 3'd1, CELL_SHIFT_DOWN = 3'd2,
      CELL_WRITE = 3'd3, CELL_SWAP = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type  op;
      logic [31:0]  data;
      logic         odd_phase;   // which pairs compare during a swap pass
      logic         descending;
   } cell_ctl_type;
endpackage

FILE: rtl/core/bsle_if.sv
// Valid/ready channel interface used for the request and response sides.
// Depends on nothing.
`timescale 1ns / 1ps
interface bsle_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/bsle_cell.sv
// One element cell of the list chain: holds one value, talks to both neighbors.
// Depends on bsle_pkg.
`timescale 1ns / 1ps
module bsle_cell (
   input  logic                  clock,
   input  bsle_pkg::cell_ctl_type ctl,
   input  logic                  shift_en,    // this cell takes part in a shift
   input  logic                  write_en,    // this cell is the write target
   input  logic                  is_even,     // index parity
   input  logic                  swap_en,     // pair partner exists within the list
   input  logic [31:0]           lower_val,   // neighbor at index - 1
   input  logic [31:0]           upper_val,   // neighbor at index + 1
   output logic [31:0]           val
);
   logic [31:0] val_ff, val_in;
   logic        is_low, lo_gt, do_sw;
   logic [31:0] partner;

   always_comb begin
      // During a pass, a cell is the low member of its pair when its parity
      // matches the phase.
      is_low  = (is_even != ctl.odd_phase);
      partner = is_low ? upper_val : lower_val;
      lo_gt   = is_low ? ($signed(val_ff) > $signed(partner))
                       : ($signed(partner) > $signed(val_ff));
      do_sw   = swap_en && (ctl.descending ? !lo_gt &&
                (is_low ? $signed(val_ff) != $signed(partner)
                        : $signed(partner) != $signed(val_ff)) : lo_gt);
      val_in = val_ff;
      case (ctl.op)
         bsle_pkg::CELL_SHIFT_UP: begin
            if (write_en) val_in = ctl.data;
            else if (shift_en) val_in = lower_val;
         end
         bsle_pkg::CELL_SHIFT_DOWN: if (shift_en) val_in = upper_val;
         bsle_pkg::CELL_WRITE: if (write_en) val_in = ctl.data;
         bsle_pkg::CELL_SWAP: if (do_sw) val_in = partner;
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end
   assign val = val_ff;
endmodule

FILE: rtl/core/bounded_sequential_list_engine_unit.sv
// Top level of the list engine: sequencer plus a chain of element cells.
// Depends on bsle_pkg, bsle_if and bsle_cell.
//
//   channel  dir  payload
//   req      in   action, value, position, replacement
//   rsp      out  status, read_data, found_index, removed_count, list_size
//
// Simple reads, writes, pops of the tail and inserts leave the scan state at
// once, directly or through the work state. Linear searches, deletes and
// replace-all walk the list, one cell a cycle. Sorts run as many odd/even
// transposition passes through the cell chain as the list holds elements.
// Reset is synchronous and clears only the size and control; cells hold junk.
// A result stays in the output register until taken; the next request is
// accepted once the previous result has been taken or in that same cycle.
`timescale 1ns / 1ps
module bounded_sequential_list_engine_unit #(
   parameter int CAPACITY = 64
) (
   input logic    clock,
   input logic    reset,
   bsle_if.sink   req,
   bsle_if.source rsp
);
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   // Width wide enough to compare the position against the size.
   localparam int XW = (CW > 7) ? CW + 1 : 8;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_WORK = 5'b00100,
      S_SORT = 5'b01000, S_DONE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         act_ff, act_in;
   logic [31:0]        value_ff, value_in, repl_ff, repl_in;
   logic [6:0]         pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;      // scan pointer
   logic [CW-1:0]      hit_ff, hit_in;      // last/first match or target
   logic               hitv_ff, hitv_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in, wr_ff, wr_in;
   logic [CW-1:0]      pass_ff, pass_in;
   logic [6:0]         rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         st_ff, st_in;
   logic [31:0]        rd_ff, rd_in;
   logic [5:0]         fi_ff, fi_in;
   logic [6:0]         rc_ff, rc_in;
   bsle_pkg::cell_ctl_type ctl;
   logic [CAPACITY-1:0] shift_en, write_en, swap_en;
   logic [31:0]        cv [CAPACITY];
   logic [31:0]        cur, mid_v;
   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic [CW-1:0]      shift_lo, shift_hi, wr_idx;
   logic               req_take, rsp_free;

   logic [3:0]   r_act;
   logic [31:0]  r_value, r_repl;
   logic [6:0]   r_pos;
   assign {r_act, r_value, r_pos, r_repl} = req.payload;

   // Cell row; index multiplexing for scans and reads goes through one read mux.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] lo_n, up_n;
      if (g == 0) begin : g_lo0
         assign lo_n = 32'd0;
      end else begin : g_lon
         assign lo_n = cv[g-1];
      end
      if (g == CAPACITY - 1) begin : g_upl
         assign up_n = 32'd0;
      end else begin : g_upn
         assign up_n = cv[g+1];
      end
      assign shift_en[g] = (CW'(g) >= shift_lo) && (CW'(g) < shift_hi);
      assign write_en[g] = (CW'(g) == wr_idx);
      assign swap_en[g]  = ((g % 2 == 0) != ctl.odd_phase)
                           ? (CW'(g + 1) < count_ff) : (g != 0 && CW'(g) < count_ff);
      bsle_cell u_cell (
         .clock(clock), .ctl(ctl), .shift_en(shift_en[g]), .write_en(write_en[g]),
         .is_even(g % 2 == 0), .swap_en(swap_en[g]), .lower_val(lo_n),
         .upper_val(up_n), .val(cv[g])
      );
   end

   assign cur     = cv[idx_ff[IW-1:0]];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign mid_v   = cv[mid[IW-1:0]];

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_take  = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = {st_ff, rd_ff, fi_ff, rc_ff, 7'(count_ff)};

   always_comb begin
      state_in = state_ff; act_in = act_ff; value_in = value_ff; repl_in = repl_ff;
      pos_in = pos_ff; count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff;
      hitv_in = hitv_ff; lo_in = lo_ff; hi_in = hi_ff; wr_in = wr_ff;
      pass_in = pass_ff; rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      st_in = st_ff; rd_in = rd_ff; fi_in = fi_ff; rc_in = rc_ff;
      ctl = '{op: bsle_pkg::CELL_HOLD, data: value_ff, odd_phase: pass_ff[0],
              descending: (act_ff == bsle_pkg::ACT_SORT_DOWN)};
      shift_lo = '0; shift_hi = '0; wr_idx = CW'(CAPACITY);
      case (state_ff)
         S_IDLE: if (req_take) begin
            act_in = r_act; value_in = r_value; repl_in = r_repl; pos_in = r_pos;
            idx_in = '0; hitv_in = 1'b0; hit_in = count_ff; rem_in = '0;
            wr_in = '0; lo_in = '0; hi_in = count_ff; pass_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Walk the cells one per cycle; direct actions finish at once.
            st_in = bsle_pkg::ST_OK; rd_in = '0; fi_in = '0; rc_in = '0;
            case (act_ff)
               bsle_pkg::ACT_APPEND, bsle_pkg::ACT_PUSH_FRONT,
               bsle_pkg::ACT_INSERT_AT: begin
                  hit_in = (act_ff == bsle_pkg::ACT_APPEND) ? count_ff :
                           (act_ff == bsle_pkg::ACT_PUSH_FRONT) ? '0 : CW'(pos_ff);
                  if ((act_ff == bsle_pkg::ACT_INSERT_AT) && (XW'(pos_ff) >
                      XW'(count_ff))) begin
                     st_in = bsle_pkg::ST_BADIDX; state_in = S_DONE;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     st_in = bsle_pkg::ST_FULL; state_in = S_DONE;
                  end else state_in = S_WORK;
               end
               bsle_pkg::ACT_POP_TAIL, bsle_pkg::ACT_POP_HEAD: begin
                  hit_in = '0;
                  if (count_ff == '0) begin
                     st_in = bsle_pkg::ST_EMPTY; state_in = S_DONE;
                  end else if (act_ff == bsle_pkg::ACT_POP_TAIL) begin
                     count_in = count_ff - 1'b1; state_in = S_DONE;
                  end else state_in = S_WORK;
               end
               bsle_pkg::ACT_READ, bsle_pkg::ACT_WRITE: begin
                  hit_in = CW'(pos_ff);
                  if (XW'(pos_ff) >= XW'(count_ff)) begin
                     st_in = bsle_pkg::ST_BADIDX; state_in = S_DONE;
                  end else if (act_ff == bsle_pkg::ACT_READ) begin
                     idx_in = CW'(pos_ff); state_in = S_WORK;
                  end else state_in = S_WORK;
               end
               bsle_pkg::ACT_BSEARCH: begin
                  if (lo_ff >= hi_ff) begin
                     st_in = bsle_pkg::ST_NOTFOUND; state_in = S_DONE;
                  end else if ($signed(value_ff) > $signed(mid_v)) lo_in = mid + 1'b1;
                  else if ($signed(value_ff) < $signed(mid_v)) hi_in = mid;
                  else begin
                     fi_in = 6'(mid); state_in = S_DONE;
                  end
               end
               bsle_pkg::ACT_SORT_UP, bsle_pkg::ACT_SORT_DOWN: state_in = S_SORT;
               bsle_pkg::ACT_DEL_FIRST, bsle_pkg::ACT_DEL_ALL, bsle_pkg::ACT_FIND,
               bsle_pkg::ACT_REPL_LAST, bsle_pkg::ACT_REPL_ALL: begin
                  if (idx_ff < count_ff) begin
                     idx_in = idx_ff + 1'b1;
                     if (cur == value_ff) begin
                        if (act_ff == bsle_pkg::ACT_DEL_ALL) begin
                           rem_in = rem_ff + 1'b1;
                        end else if (act_ff == bsle_pkg::ACT_REPL_ALL) begin
                           ctl.op = bsle_pkg::CELL_WRITE; ctl.data = repl_ff;
                           wr_idx = idx_ff;
                        end else if (!(hitv_ff && act_ff == bsle_pkg::ACT_DEL_FIRST))
                        begin
                           hit_in = idx_ff; hitv_in = 1'b1;
                        end
                     end
                     if (act_ff == bsle_pkg::ACT_DEL_ALL && cur != value_ff) begin
                        // Compaction: keep element written back to the write index.
                        ctl.op = bsle_pkg::CELL_WRITE; ctl.data = cur; wr_idx = wr_ff;
                        wr_in = wr_ff + 1'b1;
                     end
                  end else begin
                     case (act_ff)
                        bsle_pkg::ACT_DEL_ALL: begin
                           count_in = wr_ff; rc_in = rem_ff; state_in = S_DONE;
                        end
                        bsle_pkg::ACT_REPL_ALL: state_in = S_DONE;
                        default: begin
                           if (!hitv_ff) begin
                              st_in = bsle_pkg::ST_NOTFOUND; state_in = S_DONE;
                           end else if (act_ff == bsle_pkg::ACT_DEL_FIRST) begin
                              state_in = S_WORK;
                           end else begin
                              fi_in = 6'(hit_ff);
                              state_in = (act_ff == bsle_pkg::ACT_REPL_LAST)
                                         ? S_WORK : S_DONE;
                           end
                        end
                     endcase
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WORK: begin
            state_in = S_DONE;
            case (act_ff)
               bsle_pkg::ACT_APPEND, bsle_pkg::ACT_PUSH_FRONT,
               bsle_pkg::ACT_INSERT_AT: begin
                  ctl.op = bsle_pkg::CELL_SHIFT_UP; ctl.data = value_ff;
                  shift_lo = hit_ff + 1'b1; shift_hi = count_ff + 1'b1; wr_idx = hit_ff;
                  count_in = count_ff + 1'b1;
               end
               bsle_pkg::ACT_READ: rd_in = cur;
               bsle_pkg::ACT_WRITE: begin
                  ctl.op = bsle_pkg::CELL_WRITE; wr_idx = hit_ff;
               end
               bsle_pkg::ACT_REPL_LAST: begin
                  ctl.op = bsle_pkg::CELL_WRITE; ctl.data = repl_ff; wr_idx = hit_ff;
               end
               default: begin // pop head, delete first
                  ctl.op = bsle_pkg::CELL_SHIFT_DOWN;
                  shift_lo = hit_ff; shift_hi = count_ff - 1'b1;
                  count_in = count_ff - 1'b1;
               end
            endcase
         end
         S_SORT: begin
            ctl.op = bsle_pkg::CELL_SWAP;
            pass_in = pass_ff + 1'b1;
            if (pass_ff >= count_ff) begin
               ctl.op = bsle_pkg::CELL_HOLD; state_in = S_DONE;
            end
         end
         S_DONE: if (rsp_free) begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in; value_ff <= value_in; repl_ff <= repl_in; pos_ff <= pos_in;
      idx_ff <= idx_in; hit_ff <= hit_in; hitv_ff <= hitv_in; lo_ff <= lo_in;
      hi_ff <= hi_in; wr_ff <= wr_in; pass_ff <= pass_in; rem_ff <= rem_in;
      st_ff <= st_in; rd_ff <= rd_in; fi_ff <= fi_in; rc_ff <= rc_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("list size beyond capacity");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_SCAN) else $error("accepted request not started");
endmodule

FILE: tb/bounded_sequential_list_engine_unit_tb.sv
// Self-checking testbench for the bounded list engine: directed table, then random traffic.
// Depends on bsle_pkg, bsle_if and the bounded_sequential_list_engine_unit RTL.
`timescale 1ns / 1ps
module bounded_sequential_list_engine_unit_tb;

   localparam int CAP = 64;
   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      bsle_pkg::action_type action;
      logic signed [31:0]   value;
      logic [6:0]           position;
      logic signed [31:0]   replacement;
   } list_req_type;

   typedef struct packed {
      bsle_pkg::status_type status;
      logic signed [31:0]   read_data;
      logic [5:0]           found_index;
      logic [6:0]           removed_count;
      logic [6:0]           list_size;
   } list_rsp_type;

   typedef struct {
      list_req_type r;
      bit           typed;
      list_rsp_type e;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsle_if #(.WIDTH($bits(list_req_type))) req_if ();
   bsle_if #(.WIDTH($bits(list_rsp_type))) rsp_if ();

   bounded_sequential_list_engine_unit #(.CAPACITY(CAP)) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   always #1 clock = ~clock;

   // Shadow copy of the list contents.
   logic signed [31:0] shadow_list[CAP];
   int                 shadow_size = 0;
   list_rsp_type       pending_rsp[$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 sender_done = 1'b0;
   table_row_type      directed[$];

   function automatic void shadow_insert(int pos, logic signed [31:0] v);
      for (int i = shadow_size; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
      shadow_list[pos] = v;
      shadow_size++;
   endfunction

   function automatic void shadow_remove(int pos);
      for (int i = pos; i + 1 < shadow_size; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_size--;
   endfunction

   function automatic list_rsp_type predict_list_op(list_req_type q);
      list_rsp_type       o;
      int                 pos, p, j, l, rr, mid;
      logic signed [31:0] v;
      bit                 hit;
      o = '0;
      o.status = bsle_pkg::ST_OK;
      pos = q.position;
      case (q.action)
         bsle_pkg::ACT_APPEND, bsle_pkg::ACT_PUSH_FRONT, bsle_pkg::ACT_INSERT_AT: begin
            if (q.action == bsle_pkg::ACT_APPEND) pos = shadow_size;
            else if (q.action == bsle_pkg::ACT_PUSH_FRONT) pos = 0;
            if (pos > shadow_size) o.status = bsle_pkg::ST_BADIDX;
            else if (shadow_size >= CAP) o.status = bsle_pkg::ST_FULL;
            else shadow_insert(pos, q.value);
         end
         bsle_pkg::ACT_POP_TAIL: begin
            if (shadow_size == 0) o.status = bsle_pkg::ST_EMPTY;
            else shadow_size--;
         end
         bsle_pkg::ACT_POP_HEAD: begin
            if (shadow_size == 0) o.status = bsle_pkg::ST_EMPTY;
            else shadow_remove(0);
         end
         bsle_pkg::ACT_DEL_FIRST: begin
            for (p = 0; p < shadow_size; p++) if (shadow_list[p] == q.value) break;
            if (p >= shadow_size) o.status = bsle_pkg::ST_NOTFOUND;
            else shadow_remove(p);
         end
         bsle_pkg::ACT_DEL_ALL: begin
            j = 0;
            for (int i = 0; i < shadow_size; i++) begin
               if (shadow_list[i] != q.value) shadow_list[j++] = shadow_list[i];
               else o.removed_count++;
            end
            shadow_size = j;
         end
         bsle_pkg::ACT_FIND, bsle_pkg::ACT_REPL_LAST: begin
            p = -1;
            for (int i = 0; i < shadow_size; i++) if (shadow_list[i] == q.value) p = i;
            if (p < 0) o.status = bsle_pkg::ST_NOTFOUND;
            else begin
               o.found_index = p[5:0];
               if (q.action == bsle_pkg::ACT_REPL_LAST) shadow_list[p] = q.replacement;
            end
         end
         bsle_pkg::ACT_BSEARCH: begin
            l = 0;
            rr = shadow_size;
            hit = 1'b0;
            while (l < rr) begin
               mid = (l + rr) / 2;
               if (q.value > shadow_list[mid]) l = mid + 1;
               else if (q.value < shadow_list[mid]) rr = mid;
               else begin
                  o.found_index = mid[5:0];
                  hit = 1'b1;
                  break;
               end
            end
            if (!hit) o.status = bsle_pkg::ST_NOTFOUND;
         end
         bsle_pkg::ACT_READ: begin
            if (pos >= shadow_size) o.status = bsle_pkg::ST_BADIDX;
            else o.read_data = shadow_list[pos];
         end
         bsle_pkg::ACT_WRITE: begin
            if (pos >= shadow_size) o.status = bsle_pkg::ST_BADIDX;
            else shadow_list[pos] = q.value;
         end
         bsle_pkg::ACT_REPL_ALL: begin
            for (int i = 0; i < shadow_size; i++)
               if (shadow_list[i] == q.value) shadow_list[i] = q.replacement;
         end
         bsle_pkg::ACT_SORT_UP, bsle_pkg::ACT_SORT_DOWN: begin
            for (int i = 1; i < shadow_size; i++) begin
               v = shadow_list[i];
               j = i;
               while (j > 0 && ((q.action == bsle_pkg::ACT_SORT_DOWN)
                                ? (shadow_list[j - 1] < v)
                                : (shadow_list[j - 1] > v))) begin
                  shadow_list[j] = shadow_list[j - 1];
                  j--;
               end
               shadow_list[j] = v;
            end
         end
         default: ;
      endcase
      o.list_size = shadow_size[6:0];
      return o;
   endfunction

   function automatic void add_row(bsle_pkg::action_type a, logic signed [31:0] v,
                                   int pos, logic signed [31:0] rep, bit typed = 1'b0,
                                   bsle_pkg::status_type st = bsle_pkg::ST_OK,
                                   logic signed [31:0] rd = 0, int sz = 0);
      table_row_type t;
      t.r = '{action: a, value: v, position: pos[6:0], replacement: rep};
      t.typed = typed;
      t.e = '{status: st, read_data: rd, found_index: '0, removed_count: '0,
              list_size: sz[6:0]};
      directed.push_back(t);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 7)) - 32'sd3;
      endcase
   endfunction

   function automatic list_req_type random_request(bit fill);
      list_req_type q;
      int           roll;
      roll = $urandom_range(0, 99);
      q.value = pick_value();
      q.replacement = ($urandom_range(0, 1) != 0) ? pick_value() : $urandom;
      q.position = ($urandom_range(0, 9) == 0) ? 7'd64 :
                   7'($urandom_range(0, (shadow_size < 63) ? shadow_size + 1 : 64));
      if (fill && roll < 60) q.action = bsle_pkg::action_type'($urandom_range(0, 2));
      else if (!fill && roll < 40) q.action = bsle_pkg::action_type'($urandom_range(3, 6));
      else q.action = bsle_pkg::action_type'($urandom_range(0, 15));
      return q;
   endfunction

   task automatic send_request(list_req_type q, bit typed, list_rsp_type e);
      list_rsp_type p;
      int           gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= q;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      p = predict_list_op(q);
      pending_rsp.push_back(typed ? e : p);
   endtask

   // Sender: directed table first, then random traffic alternating fill and drain phases.
   initial begin
      list_rsp_type none;
      none = '0;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      add_row(bsle_pkg::ACT_POP_TAIL, 0, 0, 0, 1, bsle_pkg::ST_EMPTY);
      add_row(bsle_pkg::ACT_POP_HEAD, 0, 0, 0, 1, bsle_pkg::ST_EMPTY);
      add_row(bsle_pkg::ACT_DEL_FIRST, 5, 0, 0, 1, bsle_pkg::ST_NOTFOUND);
      add_row(bsle_pkg::ACT_FIND, 5, 0, 0, 1, bsle_pkg::ST_NOTFOUND);
      add_row(bsle_pkg::ACT_BSEARCH, 5, 0, 0, 1, bsle_pkg::ST_NOTFOUND);
      add_row(bsle_pkg::ACT_REPL_LAST, 5, 0, 9, 1, bsle_pkg::ST_NOTFOUND);
      add_row(bsle_pkg::ACT_READ, 0, 0, 0, 1, bsle_pkg::ST_BADIDX);
      add_row(bsle_pkg::ACT_WRITE, 1, 0, 0, 1, bsle_pkg::ST_BADIDX);
      add_row(bsle_pkg::ACT_DEL_ALL, 5, 0, 0, 1, bsle_pkg::ST_OK);
      add_row(bsle_pkg::ACT_REPL_ALL, 5, 0, 9, 1, bsle_pkg::ST_OK);
      add_row(bsle_pkg::ACT_SORT_UP, 0, 0, 0, 1, bsle_pkg::ST_OK);
      add_row(bsle_pkg::ACT_NONE, -1, 127, -1, 1, bsle_pkg::ST_OK);
      add_row(bsle_pkg::ACT_INSERT_AT, 3, 1, 0, 1, bsle_pkg::ST_BADIDX);
      add_row(bsle_pkg::ACT_APPEND, 32'sh7fffffff, 0, 0, 1, bsle_pkg::ST_OK, 0, 1);
      add_row(bsle_pkg::ACT_PUSH_FRONT, 32'sh80000000, 0, 0, 1, bsle_pkg::ST_OK, 0, 2);
      add_row(bsle_pkg::ACT_INSERT_AT, 0, 1, 0, 1, bsle_pkg::ST_OK, 0, 3);
      add_row(bsle_pkg::ACT_READ, 0, 2, 0, 1, bsle_pkg::ST_OK, 32'sh7fffffff, 3);
      add_row(bsle_pkg::ACT_READ, 0, 64, 0, 1, bsle_pkg::ST_BADIDX, 0, 3);
      add_row(bsle_pkg::ACT_SORT_DOWN, 0, 0, 0);
      add_row(bsle_pkg::ACT_BSEARCH, 0, 0, 0);
      add_row(bsle_pkg::ACT_SORT_UP, 0, 0, 0);
      add_row(bsle_pkg::ACT_BSEARCH, 32'sh7fffffff, 0, 0);
      add_row(bsle_pkg::ACT_REPL_LAST, 0, 0, -7);
      add_row(bsle_pkg::ACT_APPEND, -7, 0, 0);
      add_row(bsle_pkg::ACT_DEL_ALL, -7, 0, 0);
      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (directed[i]) send_request(directed[i].r, directed[i].typed, directed[i].e);
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_request(random_request(((n / 150) % 2) == 0), 1'b0, none);
      req_if.valid <= 1'b0;
      sender_done = 1'b1;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Receiver: random stalls, plus one long hold so the engine backs up.
   initial begin
      int gap;
      int n_taken;
      n_taken = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (n_taken == 200) gap = LONG_HOLD;
         else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         n_taken++;
      end
   end

   always @(posedge clock) begin
      list_rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response transfer: %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Response mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (sender_done && pending_rsp.size() == 0))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end
endmodule
